// ===== rtl/cpvp_pkg.sv =====
package cpvp_pkg;

  localparam int unsigned ProdW = 82;

  // Noise constants and fixed-point ones
  localparam logic [40:0] KfQn     = 41'd13207024;
  localparam logic [41:0] KfRn     = 42'd17976148175;
  localparam logic [30:0] One30    = 31'd1073741824;
  localparam logic [39:0] CovReset = 40'd32212254720;
  localparam logic signed [47:0] EstReset = 48'sd65536;
  localparam logic signed [14:0] SpikeLimit = 15'sd3000;

  localparam logic signed [47:0] Max48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Min48 = 48'sh8000_0000_0000;
  localparam logic [81:0] Lim47 = 82'd140737488355328;

  // Register indexes
  localparam logic [3:0] RegPosKp = 4'd0;
  localparam logic [3:0] RegPosKi = 4'd1;
  localparam logic [3:0] RegPosKd = 4'd2;
  localparam logic [3:0] RegVelKp = 4'd3;
  localparam logic [3:0] RegVelKi = 4'd4;
  localparam logic [3:0] RegVelKd = 4'd5;
  localparam logic [3:0] RegCurUp = 4'd6;
  localparam logic [3:0] RegCurLo = 4'd7;

  typedef struct packed {
    logic               start;
    logic signed [48:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic              neg;
    logic [ProdW-1:0]  prod;
  } mul_rsp_t;

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v > 52'(Max48)) r = Max48;
    else if (v < 52'(Min48)) r = Min48;
    else r = v[47:0];
    return r;
  endfunction

  // Shift product magnitude, truncate toward zero, saturate to 48 bits
  function automatic logic signed [47:0] mul_fin(input logic [ProdW-1:0] prod,
                                                 input logic neg, input logic sh30);
    logic [ProdW-1:0] shv;
    logic [ProdW-1:0] mag;
    logic signed [47:0] r;
    shv = sh30 ? (prod >> 30) : (prod >> 16);
    mag = (shv > Lim47) ? Lim47 : shv;
    if (neg) r = 48'(-$signed({1'b0, mag[47:0]}));
    else if (mag > Lim47 - 82'd1) r = Max48;
    else r = $signed(mag[47:0]);
    return r;
  endfunction

endpackage

// ===== rtl/cpvp_mul.sv =====
module cpvp_mul
  import cpvp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [48:0] ma_q;
  logic [32:0] mb_q;
  logic        neg_q;
  logic [64:0] lo_q;
  logic [49:0] hi_q;
  logic [ProdW-1:0] prod_q;
  logic [2:0]  cnt_q;

  // Low and high partial products, then the combining add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      if (req_i.start) begin
        cnt_q <= 3'd1;
        ma_q  <= req_i.a[48] ? 49'(-req_i.a) : req_i.a;
        mb_q  <= req_i.b[32] ? 33'(-req_i.b) : req_i.b;
        neg_q <= req_i.a[48] ^ req_i.b[32];
      end else if (cnt_q != 3'd0) begin
        cnt_q <= (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
      end
      if (cnt_q == 3'd1) lo_q <= 65'(ma_q[31:0]) * 65'(mb_q);
      if (cnt_q == 3'd2) hi_q <= 50'(ma_q[48:32]) * 50'(mb_q);
      if (cnt_q == 3'd3) prod_q <= {hi_q, 32'b0} + ProdW'(lo_q);
    end
  end

  assign rsp_o.done = (cnt_q == 3'd4);
  assign rsp_o.neg  = neg_q;
  assign rsp_o.prod = prod_q;

endmodule

// ===== rtl/cpvp_div.sv =====
module cpvp_div
  import cpvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [40:0] num_i,
  input  logic [41:0] den_i,
  output logic        done_o,
  output logic [29:0] quo_o
);

  logic [42:0] rem_q;
  logic [41:0] den_q;
  logic [29:0] quo_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [42:0] r2;

  assign r2 = {rem_q[41:0], 1'b0};

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= 43'(num_i);
        den_q  <= den_i;
        quo_q  <= '0;
      end else if (busy_q) begin
        if (r2 >= 43'(den_q)) begin
          rem_q <= r2 - 43'(den_q);
          quo_q <= {quo_q[28:0], 1'b1};
        end else begin
          rem_q <= r2;
          quo_q <= {quo_q[28:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd29) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== rtl/cascade_position_velocity_pid_top.sv =====
// Steps per input transaction: three position-loop products on the shared
// multiplier, the Kalman gain divider, three covariance and filter products,
// the velocity error state, three velocity-loop products, then the split and
// clamp state. Input is ready only while idle, so a new item is not taken until
// the last is through; a result still held by the sink stalls the next item at the split.
// Reset (rst_ni, async, active low) loads default gains, limits and filter state.
module cascade_position_velocity_pid_top
  import cpvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [12:0] angle_measured, [25:13] angle_target
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // tdata: [15:0] current_command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  // tuser: [0] was_limited
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_WAIT, S_DIV, S_VERR, S_SPLIT} state_e;
  typedef enum logic [3:0] {OP_PKP, OP_PKI, OP_PKD, OP_CLO, OP_CHI, OP_KAL,
                            OP_VKP, OP_VKI, OP_VKD} op_e;

  state_e state_q;
  op_e    op_q;

  logic signed [31:0] pkp_q, pki_q, pkd_q, vkp_q, vki_q, vkd_q;
  logic signed [15:0] cup_q, clo_q;

  logic [12:0]        last_angle_q;
  logic signed [29:0] last_err_q, perr_q;
  logic signed [47:0] asum_q, fv_q, lverr_q, vsum_q, verr_q, x_q, z_q, vt_q, tot_q;
  logic signed [30:0] pdiff_q;
  logic signed [48:0] vdiff_q;
  logic signed [16:0] crem_q;
  logic [39:0]        cov_q, ctmp_q;
  logic [29:0]        k_q;
  logic [30:0]        omk_q;
  logic signed [50:0] acc_q;

  logic        out_valid_q, out_lim_q;
  logic [15:0] out_cmd_q;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic        div_start, div_done;
  logic [29:0] div_k;
  logic [40:0] pp;
  logic [41:0] den;

  assign pp  = 41'(cov_q) + KfQn;
  assign den = 42'(pp) + KfRn;

  cpvp_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));
  cpvp_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(pp), .den_i(den),
                  .done_o(div_done), .quo_o(div_k));

  // Input decode
  logic [12:0] meas, tgt;
  logic signed [13:0] d14, step;
  logic signed [29:0] perr;
  logic spike;
  assign meas  = s_axis_tdata[12:0];
  assign tgt   = s_axis_tdata[25:13];
  assign d14   = $signed({1'b0, tgt}) - $signed({1'b0, meas});
  assign perr  = {d14, 16'b0};
  assign step  = $signed({1'b0, meas}) - $signed({1'b0, last_angle_q});
  assign spike = (15'(step) > SpikeLimit) || (15'(step) < -SpikeLimit);

  // Operand select for the shared multiplier
  always_comb begin
    mreq.start = (state_q == S_LOAD);
    mreq.a = '0;
    mreq.b = '0;
    case (op_q)
      OP_PKP: begin mreq.a = 49'(perr_q);   mreq.b = 33'(pkp_q); end
      OP_PKI: begin mreq.a = 49'(asum_q);   mreq.b = 33'(pki_q); end
      OP_PKD: begin mreq.a = 49'(pdiff_q);  mreq.b = 33'(pkd_q); end
      OP_CLO: begin mreq.a = $signed({18'b0, omk_q}); mreq.b = $signed({3'b0, pp[29:0]}); end
      OP_CHI: begin mreq.a = $signed({18'b0, omk_q}); mreq.b = $signed({22'b0, pp[40:30]}); end
      OP_KAL: begin mreq.a = 49'(z_q) - 49'(x_q);     mreq.b = $signed({3'b0, k_q}); end
      OP_VKP: begin mreq.a = 49'(verr_q);   mreq.b = 33'(vkp_q); end
      OP_VKI: begin mreq.a = 49'(vsum_q);   mreq.b = 33'(vki_q); end
      OP_VKD: begin mreq.a = vdiff_q;       mreq.b = 33'(vkd_q); end
      default: ;
    endcase
  end

  logic signed [47:0] mres, xnew, verr_n;
  logic [ProdW-1:0]   cov_lo;
  assign mres   = mul_fin(mrsp.prod, mrsp.neg, op_q == OP_KAL);
  assign cov_lo = mrsp.prod >> 30;
  assign xnew   = sat48(52'(x_q) + 52'(mres));
  assign verr_n = sat48(52'(vt_q) - 52'(fv_q));

  // Integer split and clamp
  logic [15:0]        frac;
  logic signed [31:0] ipart, cmd, cupx, clox;
  logic signed [16:0] rem17;
  logic               lim;
  always_comb begin
    frac  = tot_q[15:0];
    ipart = tot_q[47:16];
    rem17 = $signed({1'b0, frac});
    if (tot_q[47] && frac != 16'd0) begin
      ipart = ipart + 32'sd1;
      rem17 = $signed({1'b1, frac});
    end
    cupx = 32'(cup_q);
    clox = 32'(clo_q);
    cmd  = ipart;
    lim  = 1'b0;
    if (cmd > cupx) begin cmd = cupx; lim = 1'b1; end
    if (cmd < clox) begin cmd = clox; lim = 1'b1; end
  end

  assign div_start     = (state_q == S_WAIT) && mrsp.done && (op_q == OP_PKD);
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_cmd_q;
  assign m_axis_tuser  = out_lim_q;

  // Sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_PKP;
      pkp_q <= 32'sd983;      pki_q <= 32'sd0;     pkd_q <= 32'sd0;
      vkp_q <= 32'sd13107200; vki_q <= 32'sd65536; vkd_q <= 32'sd655360;
      cup_q <= 16'sd4900;     clo_q <= -16'sd4900;
      last_angle_q <= '0; last_err_q <= '0; asum_q <= '0; fv_q <= '0;
      lverr_q <= '0; vsum_q <= '0; crem_q <= '0;
      x_q <= EstReset; cov_q <= CovReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegPosKp: pkp_q <= cfg_data_i;
          RegPosKi: pki_q <= cfg_data_i;
          RegPosKd: pkd_q <= cfg_data_i;
          RegVelKp: vkp_q <= cfg_data_i;
          RegVelKi: vki_q <= cfg_data_i;
          RegVelKd: vkd_q <= cfg_data_i;
          RegCurUp: cup_q <= cfg_data_i[15:0];
          RegCurLo: clo_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // The split state reloads the result register itself
      if (out_valid_q && m_axis_tready && (state_q != S_SPLIT)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            perr_q       <= perr;
            asum_q       <= sat48(52'(asum_q) + 52'(perr));
            pdiff_q      <= 31'(perr) - 31'(last_err_q);
            last_err_q   <= perr;
            last_angle_q <= meas;
            z_q          <= spike ? fv_q : {{18{step[13]}}, step, 16'b0};
            acc_q        <= '0;
            op_q         <= OP_PKP;
            state_q      <= S_LOAD;
          end
        end
        S_LOAD: state_q <= S_WAIT;
        S_WAIT: begin
          if (mrsp.done) begin
            state_q <= S_LOAD;
            case (op_q)
              OP_PKP: begin acc_q <= acc_q + 51'(mres); op_q <= OP_PKI; end
              OP_PKI: begin acc_q <= acc_q + 51'(mres); op_q <= OP_PKD; end
              OP_PKD: begin
                vt_q    <= sat48(52'(acc_q) + 52'(mres));
                state_q <= S_DIV;
              end
              OP_CLO: begin ctmp_q <= cov_lo[39:0]; op_q <= OP_CHI; end
              OP_CHI: begin cov_q <= mrsp.prod[39:0] + ctmp_q; op_q <= OP_KAL; end
              OP_KAL: begin
                x_q     <= xnew;
                fv_q    <= xnew;
                state_q <= S_VERR;
              end
              OP_VKP: begin acc_q <= acc_q + 51'(mres); op_q <= OP_VKI; end
              OP_VKI: begin acc_q <= acc_q + 51'(mres); op_q <= OP_VKD; end
              OP_VKD: begin
                tot_q   <= sat48(52'(acc_q) + 52'(mres) + 52'(crem_q));
                state_q <= S_SPLIT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            k_q     <= div_k;
            omk_q   <= One30 - 31'(div_k);
            op_q    <= OP_CLO;
            state_q <= S_LOAD;
          end
        end
        S_VERR: begin
          verr_q  <= verr_n;
          vsum_q  <= sat48(52'(vsum_q) + 52'(verr_n));
          vdiff_q <= 49'(verr_n) - 49'(lverr_q);
          lverr_q <= verr_n;
          acc_q   <= '0;
          op_q    <= OP_VKP;
          state_q <= S_LOAD;
        end
        S_SPLIT: begin
          if (!out_valid_q || m_axis_tready) begin
            crem_q      <= rem17;
            out_cmd_q   <= cmd[15:0];
            out_lim_q   <= lim;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/cascade_position_velocity_pid_top_tb.sv =====
`timescale 1ns / 1ps

module cascade_position_velocity_pid_top_tb;
  import cpvp_pkg::*;

  localparam longint Sat48Hi = 64'sd140737488355327;
  localparam longint Sat48Lo = -64'sd140737488355328;
  localparam logic [127:0] ProcNoise = 128'd13207024;
  localparam logic [127:0] MeasNoise = 128'd17976148175;
  localparam logic [127:0] OneQ30 = 128'd1073741824;
  localparam longint OneQ16 = 64'sd65536;
  localparam longint StepLimit = 64'sd3000;
  localparam logic [3:0] RegUnusedLo = 4'd8;
  localparam logic [3:0] RegUnusedHi = 4'd15;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  cascade_position_velocity_pid_top dut (.*);

  typedef struct packed {
    logic [15:0] command;
    logic        limited;
  } drive_cmd_t;

  drive_cmd_t expected_drive_q[$];
  int         fail_count = 0;
  int         sink_hold = 0;
  int         walk_angle = 0;

  // Controller model state
  longint pos_kp, pos_ki, pos_kd, vel_kp, vel_ki, vel_kd, cur_upper, cur_lower;
  longint prev_angle, prev_angle_err, angle_err_acc, vel_filtered;
  longint prev_vel_err, vel_err_acc, cmd_fraction, est_velocity;
  logic [127:0] est_covariance;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint clip48(longint v);
    if (v > Sat48Hi) return Sat48Hi;
    if (v < Sat48Lo) return Sat48Lo;
    return v;
  endfunction

  // Signed product scaled down, truncated toward zero, saturated to 48 bits
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic [127:0] ma, mb, m;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = 128'(a < 0 ? -a : a);
    mb = 128'(b < 0 ? -b : b);
    m = (ma * mb) >> sh;
    if (m > 128'd140737488355328) m = 128'd140737488355328;
    if (neg) return -longint'(m[63:0]);
    if (m > 128'd140737488355327) m = 128'd140737488355327;
    return longint'(m[63:0]);
  endfunction

  task automatic reset_controller_model();
    pos_kp = 983; pos_ki = 0; pos_kd = 0;
    vel_kp = 13107200; vel_ki = 65536; vel_kd = 655360;
    cur_upper = 4900; cur_lower = -4900;
    prev_angle = 0; prev_angle_err = 0; angle_err_acc = 0; vel_filtered = 0;
    prev_vel_err = 0; vel_err_acc = 0; cmd_fraction = 0;
    est_velocity = OneQ16;
    est_covariance = 128'd30 * OneQ30;
  endtask

  task automatic apply_gain(logic [3:0] idx, logic [31:0] val);
    case (idx)
      RegPosKp: pos_kp = longint'($signed(val));
      RegPosKi: pos_ki = longint'($signed(val));
      RegPosKd: pos_kd = longint'($signed(val));
      RegVelKp: vel_kp = longint'($signed(val));
      RegVelKi: vel_ki = longint'($signed(val));
      RegVelKd: vel_kd = longint'($signed(val));
      RegCurUp: cur_upper = longint'($signed(val[15:0]));
      RegCurLo: cur_lower = longint'($signed(val[15:0]));
      default: ;
    endcase
  endtask

  // One control tick: outer loop, velocity filter, inner loop, saturation
  function automatic drive_cmd_t control_tick(int meas, int tgt);
    longint perr, pdiff, vtarget, step, raw, verr, vdiff, total, ipart, cmd;
    logic [127:0] pp, gain;
    drive_cmd_t r;
    r.limited = 1'b0;
    perr = longint'(tgt - meas) * OneQ16;
    angle_err_acc = clip48(angle_err_acc + perr);
    pdiff = perr - prev_angle_err;
    prev_angle_err = perr;
    vtarget = clip48(scaled_product(perr, pos_kp, 16) +
                     scaled_product(angle_err_acc, pos_ki, 16) +
                     scaled_product(pdiff, pos_kd, 16));
    step = longint'(meas) - prev_angle;
    prev_angle = meas;
    raw = (step < -StepLimit || step > StepLimit) ? vel_filtered : step * OneQ16;
    // scalar Kalman update
    pp = est_covariance + ProcNoise;
    gain = (pp << 30) / (pp + MeasNoise);
    est_covariance = (((OneQ30 - gain) * pp) >> 30) & ((128'd1 << 40) - 1);
    est_velocity = clip48(est_velocity +
                          scaled_product(raw - est_velocity, longint'(gain[63:0]), 30));
    vel_filtered = est_velocity;
    verr = clip48(vtarget - vel_filtered);
    vel_err_acc = clip48(vel_err_acc + verr);
    vdiff = verr - prev_vel_err;
    prev_vel_err = verr;
    total = clip48(scaled_product(verr, vel_kp, 16) +
                   scaled_product(vel_err_acc, vel_ki, 16) +
                   scaled_product(vdiff, vel_kd, 16) + cmd_fraction);
    ipart = total / OneQ16;
    cmd_fraction = total - ipart * OneQ16;
    cmd = ipart;
    if (cmd > cur_upper) begin cmd = cur_upper; r.limited = 1'b1; end
    if (cmd < cur_lower) begin cmd = cur_lower; r.limited = 1'b1; end
    r.command = cmd[15:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  // Send one sample; the expectation is queued at acceptance
  task automatic send_angles(int meas, int tgt);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, 13'(tgt), 13'(meas)};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_drive_q.push_back(control_tick(meas, tgt));
    @(negedge clk_i);
    if (pick_gap() > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (pick_gap()) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (expected_drive_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_gain(logic [3:0] idx, logic [31:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_gain(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly a slowly moving shaft with random spikes and target jumps
  task automatic send_motion(int count);
    int tgt;
    tgt = $urandom_range(0, 8191);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) walk_angle = $urandom_range(0, 8191);
      else walk_angle = (walk_angle + $urandom_range(0, 400) - 200 + 8192) % 8192;
      if ($urandom_range(0, 9) == 0) tgt = $urandom_range(0, 8191);
      else if ($urandom_range(0, 3) == 0) tgt = (walk_angle + $urandom_range(0, 64)) % 8192;
      send_angles(walk_angle, tgt);
    end
  endtask

  task automatic test_directed_edges();
    send_angles(0, 0);
    send_angles(8191, 8191);
    send_angles(0, 8191);
    send_angles(8191, 0);
    send_angles(5191, 0);      // step of exactly -3000
    send_angles(2190, 8191);   // step just past -3000
    send_angles(5190, 5190);   // step of exactly +3000
    send_angles(8191, 0);      // step just past +3000
    send_angles(8191, 8191);
    send_angles(4096, 2048);
    send_angles(4095, 4095);
    send_angles(1, 8190);
    send_angles(8190, 1);
    send_angles(2730, 5461);
    send_angles(5461, 2730);
    drain_results();
  endtask

  task automatic test_default_gains();
    send_motion(450);
    drain_results();
  endtask

  task automatic test_random_gains(int rounds);
    repeat (rounds) begin
      write_gain(RegPosKp, $urandom_range(0, 1 << 21) - (1 << 20));
      write_gain(RegPosKi, $urandom_range(0, 1 << 10) - (1 << 9));
      write_gain(RegPosKd, $urandom_range(0, 1 << 18) - (1 << 17));
      write_gain(RegVelKp, $urandom_range(0, 1 << 25) - (1 << 24));
      write_gain(RegVelKi, $urandom_range(0, 1 << 18) - (1 << 17));
      write_gain(RegVelKd, $urandom_range(0, 1 << 22) - (1 << 21));
      write_gain(RegCurUp, $urandom_range(0, 32767));
      write_gain(RegCurLo, -$urandom_range(0, 32768));
      send_motion(150);
      drain_results();
    end
  endtask

  // Full-scale gains drive the products and integrators into saturation
  task automatic test_extreme_gains();
    write_gain(RegPosKp, 32'h7FFF_FFFF);
    write_gain(RegPosKi, 32'h8000_0000);
    write_gain(RegPosKd, 32'h7FFF_FFFF);
    write_gain(RegVelKp, 32'h8000_0000);
    write_gain(RegVelKi, 32'h7FFF_FFFF);
    write_gain(RegVelKd, 32'h8000_0000);
    write_gain(RegCurUp, 32'h0000_7FFF);
    write_gain(RegCurLo, 32'hFFFF_8000);
    send_motion(150);
    drain_results();
    write_gain(RegPosKp, $urandom());
    write_gain(RegVelKp, $urandom());
    write_gain(RegVelKi, $urandom());
    write_gain(RegPosKi, 32'd0);
    write_gain(RegPosKd, 32'd0);
    write_gain(RegVelKd, 32'd0);
    send_motion(150);
    drain_results();
  endtask

  // Lower limit above upper, plus writes to unmapped indexes
  task automatic test_crossed_limits();
    write_gain(RegUnusedLo, $urandom());
    write_gain(RegUnusedHi, $urandom());
    write_gain(RegCurUp, 32'hFFFF_8000);
    write_gain(RegCurLo, 32'h0000_7FFF);
    send_motion(100);
    drain_results();
    write_gain(RegCurUp, -100);
    write_gain(RegCurLo, 100);
    send_motion(100);
    drain_results();
    write_gain(RegPosKp, 983);
    write_gain(RegVelKp, 13107200);
    write_gain(RegVelKi, 65536);
    write_gain(RegVelKd, 655360);
    write_gain(RegCurUp, 4900);
    write_gain(RegCurLo, -4900);
  endtask

  task automatic test_output_backpressure();
    sink_hold = 700;
    send_motion(12);
    drain_results();
  endtask

  // Result sink: random stalls, long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = (pick_gap() == 0);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    drive_cmd_t exp_d;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_drive_q.size() == 0) begin
        $error("unexpected transaction: current_command %0d",
               $signed(m_axis_tdata));
        fail_count++;
      end else begin
        exp_d = expected_drive_q.pop_front();
        if (m_axis_tdata !== exp_d.command) begin
          $error("current_command expected %0d actual %0d",
                 $signed(exp_d.command), $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tuser !== exp_d.limited) begin
          $error("was_limited expected %0b actual %0b", exp_d.limited, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegPosKp;
    cfg_data_i = '0;
    reset_controller_model();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed_edges();
    test_default_gains();
    test_output_backpressure();
    test_random_gains(3);
    test_extreme_gains();
    test_crossed_limits();
    test_default_gains();
    test_output_backpressure();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cpvp_pkg.sv
rtl/cpvp_mul.sv
rtl/cpvp_div.sv
rtl/cascade_position_velocity_pid_top.sv
tb/cascade_position_velocity_pid_top_tb.sv
